FILE: rtl/drpi_pkg.sv
// Shared types and constants for the dead-reckoning pose integrator.
// Holds sequencer state and control types, multiplier widths and the sine constants.
// No dependencies.
package drpi_pkg;

   localparam int ANGLE_BITS_DEF    = 16;
   localparam int POSITION_BITS_DEF = 32;

   // shared multiplier operand and product widths
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // position step is rounded from 2^-40 m down to 2^-16 m
   localparam int POS_SHIFT = 24;

   localparam logic [15:0] DT_MAX     = 16'hFFFF;
   localparam logic [15:0] QUARTER16  = 16'h4000;
   localparam logic [14:0] QUARTER_Q14 = 15'd16384;

   // sine polynomial coefficients, Q16
   localparam logic [16:0] SIN_A = 17'd102944;
   localparam logic [16:0] SIN_B = 17'd42048;
   localparam logic [16:0] SIN_C = 17'd4640;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ANGLE,
      ST_TRIG,
      ST_WRAP,
      ST_FINISH
   } state_type;

   // multiplier operations during ST_ANGLE
   localparam logic [2:0] OP_ROLL  = 3'd0;
   localparam logic [2:0] OP_PITCH = 3'd1;
   localparam logic [2:0] OP_YAW   = 3'd2;
   localparam logic [2:0] OP_VDT   = 3'd3;

   // multiplier operations during ST_TRIG
   localparam logic [2:0] TR_SQUARE = 3'd0;
   localparam logic [2:0] TR_CUBIC  = 3'd1;
   localparam logic [2:0] TR_QUAD   = 3'd2;
   localparam logic [2:0] TR_LIN    = 3'd3;
   localparam logic [2:0] TR_POS    = 3'd4;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef struct packed {
      state_type  state;
      logic [2:0] phase;
      logic [1:0] axis;
   } ctrl_type;

endpackage

FILE: rtl/drpi_if.sv
// Valid/ready channel interfaces for the pose integrator: velocity samples in, poses out.
// Standalone; no package dependency.
interface drpi_req_if;
   logic               valid;
   logic               ready;
   logic               restart_origin;
   logic [31:0]        sample_time;
   logic signed [15:0] linear_velocity;
   logic signed [23:0] roll_rate;
   logic signed [23:0] pitch_rate;
   logic signed [23:0] yaw_rate;

   modport source (
      output valid, restart_origin, sample_time, linear_velocity,
             roll_rate, pitch_rate, yaw_rate,
      input  ready
   );
   modport sink (
      input  valid, restart_origin, sample_time, linear_velocity,
             roll_rate, pitch_rate, yaw_rate,
      output ready
   );
endinterface

interface drpi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic [15:0]        roll_angle;
   logic [15:0]        pitch_angle;
   logic [15:0]        yaw_angle;
   logic               pose_valid;

   modport source (
      output valid, pos_x, pos_y, pos_z, roll_angle, pitch_angle, yaw_angle,
             pose_valid,
      input  ready
   );
   modport sink (
      input  valid, pos_x, pos_y, pos_z, roll_angle, pitch_angle, yaw_angle,
             pose_valid,
      output ready
   );
endinterface

FILE: rtl/dead_reckoning_pose_integrator.sv
// Top level of the dead-reckoning pose integrator: pose state, operand selection, result register.
// Depends on drpi_pkg, drpi_if (channels), drpi_seq and drpi_mul.
//
//   channel   dir  interface     carries
//   req_chan  in   drpi_req_if   restart flag, timestamp, speed, roll/pitch/yaw rates
//   rsp_chan  out  drpi_rsp_if   x/y/z position, roll/pitch/yaw angle, pose_valid
//
// A sample with a previous timestamp runs 19 products through the one shared 33x18
// multiplier (three angle steps, speed times dt, then per axis a four-product sine
// and a position product), between the accept state and the wrap and finish states.
// The very first sample goes from accept straight to finish, with no products.
// Synchronous active-high reset clears the pose, the stored timestamp and the
// result valid flag. A stalled result holds in its register; the block takes the
// next item as soon as that result has been loaded, and a finished pose waits in
// FINISH only while the result register is still full.
module dead_reckoning_pose_integrator #(
   parameter int ANGLE_BITS    = drpi_pkg::ANGLE_BITS_DEF,
   parameter int POSITION_BITS = drpi_pkg::POSITION_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   drpi_req_if.sink    req_chan,
   drpi_rsp_if.source  rsp_chan
);

   localparam int AW        = drpi_pkg::MUL_A_W;
   localparam int BW        = drpi_pkg::MUL_B_W;
   localparam int PW        = drpi_pkg::MUL_P_W;
   localparam int ANG_SHIFT = 32 - ANGLE_BITS;
   localparam int EW        = PW + POSITION_BITS;
   localparam logic signed [PW-1:0] ANG_HALF = PW'(1) << (ANG_SHIFT - 1);
   localparam logic signed [EW-1:0] POS_HALF = EW'(1) << (drpi_pkg::POS_SHIFT - 1);

   drpi_pkg::ctrl_type ctrl;
   logic               req_accept;
   logic               rsp_free;
   logic               rsp_load;

   // pose and timing state
   logic                     seen_ff, seen_in;
   logic [31:0]              prev_ff, prev_in;
   logic [15:0]              dt_ff, dt_in;
   logic                     valid_ff, valid_in;
   logic signed [POSITION_BITS-1:0] pos_ff [3];
   logic signed [POSITION_BITS-1:0] pos_in [3];
   logic [ANGLE_BITS-1:0]    att_ff [3];
   logic [ANGLE_BITS-1:0]    att_in [3];

   // sample operands held for the whole sequence
   logic signed [23:0]       roll_rate_ff, roll_rate_in;
   logic signed [23:0]       pitch_rate_ff, pitch_rate_in;
   logic signed [23:0]       yaw_rate_ff, yaw_rate_in;
   logic signed [15:0]       vel_ff, vel_in;

   // intermediate products
   logic signed [31:0]       vdt_ff, vdt_in;
   logic [14:0]              x_ff, x_in;
   logic [14:0]              x2_ff, x2_in;
   logic                     neg_ff, neg_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]       rsp_pos_ff [3];
   logic signed [31:0]       rsp_pos_in [3];
   logic [15:0]              rsp_ang_ff [3];
   logic [15:0]              rsp_ang_in [3];
   logic                     rsp_pv_ff, rsp_pv_in;

   // datapath wires
   logic [31:0]              time_diff;
   logic [15:0]              dt_sat;
   logic [ANGLE_BITS+15:0]   ang_wide [3];
   logic [15:0]              ang16 [3];
   logic [15:0]              trig_angle;
   logic [14:0]              x_cur;
   logic [16:0]              t17;
   logic signed [17:0]       s_mag;
   logic signed [17:0]       s_sig;
   logic signed [PW-1:0]     ang_sum;
   logic [ANGLE_BITS-1:0]    ang_step;
   logic signed [EW-1:0]     pos_sum;
   logic [POSITION_BITS-1:0] pos_step;
   logic signed [AW-1:0]     mul_a;
   logic signed [BW-1:0]     mul_b;
   logic signed [PW-1:0]     mul_prod;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_load   = (ctrl.state == drpi_pkg::ST_FINISH) && rsp_free;

   assign req_chan.ready = (ctrl.state == drpi_pkg::ST_IDLE);

   drpi_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (req_accept),
      .first_only (!seen_ff),
      .rsp_free   (rsp_free),
      .ctrl       (ctrl)
   );

   drpi_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (mul_prod)
   );

   // time step: wrapping difference, saturated so a backward step is the longest step
   assign time_diff = req_chan.sample_time - prev_ff;
   assign dt_sat    = (|time_diff[31:16]) ? drpi_pkg::DT_MAX : time_diff[15:0];

   // take every angle to a 16-bit binary angle (drop or append low bits)
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ang_wide[k] = {att_ff[k], 16'b0};
         ang16[k]    = ang_wide[k][ANGLE_BITS +: 16];
      end
   end

   // angle for this axis's sine: sin(yaw), cos(yaw) as sin(yaw + quarter), sin(pitch)
   always_comb begin
      case (ctrl.axis)
         drpi_pkg::AXIS_X: trig_angle = ang16[2];
         drpi_pkg::AXIS_Y: trig_angle = ang16[2] + drpi_pkg::QUARTER16;
         drpi_pkg::AXIS_Z: trig_angle = ang16[1];
         default:          trig_angle = 16'd0;
      endcase
   end

   // fold into the first quarter wave, Q14
   assign x_cur = trig_angle[14] ? (drpi_pkg::QUARTER_Q14 - {1'b0, trig_angle[13:0]})
                                 : {1'b0, trig_angle[13:0]};

   // every sine product is truncated by 14 bits; all terms are non-negative
   assign t17   = mul_prod[30:14];
   assign s_mag = $signed({1'b0, t17});
   assign s_sig = neg_ff ? -s_mag : s_mag;

   // angle step: round half up to ANGLE_BITS resolution, keep the wrapping low bits
   assign ang_sum  = mul_prod + ANG_HALF;
   assign ang_step = ang_sum[ANG_SHIFT +: ANGLE_BITS];

   // position step: round half up from 2^-40 m to 2^-16 m
   assign pos_sum  = EW'(mul_prod) + POS_HALF;
   assign pos_step = pos_sum[drpi_pkg::POS_SHIFT +: POSITION_BITS];

   // operand selection for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (ctrl.state)
         drpi_pkg::ST_ANGLE: begin
            mul_b = BW'($signed({1'b0, dt_ff}));
            case (ctrl.phase)
               drpi_pkg::OP_ROLL:  mul_a = AW'(roll_rate_ff);
               drpi_pkg::OP_PITCH: mul_a = AW'(pitch_rate_ff);
               drpi_pkg::OP_YAW:   mul_a = AW'(yaw_rate_ff);
               drpi_pkg::OP_VDT:   mul_a = AW'(vel_ff);
               default:            mul_a = '0;
            endcase
         end
         drpi_pkg::ST_TRIG: begin
            case (ctrl.phase)
               drpi_pkg::TR_SQUARE: begin
                  mul_a = AW'($signed({1'b0, x_cur}));
                  mul_b = BW'($signed({1'b0, x_cur}));
               end
               drpi_pkg::TR_CUBIC: begin
                  mul_a = AW'($signed({1'b0, drpi_pkg::SIN_C}));
                  mul_b = BW'($signed({1'b0, t17[14:0]}));
               end
               drpi_pkg::TR_QUAD: begin
                  mul_a = AW'($signed({1'b0, drpi_pkg::SIN_B - t17}));
                  mul_b = BW'($signed({1'b0, x2_ff}));
               end
               drpi_pkg::TR_LIN: begin
                  mul_a = AW'($signed({1'b0, drpi_pkg::SIN_A - t17}));
                  mul_b = BW'($signed({1'b0, x_ff}));
               end
               drpi_pkg::TR_POS: begin
                  mul_a = AW'(vdt_ff);
                  mul_b = s_sig;
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // next-state logic: each step consumes the registered product issued by the previous step
   always_comb begin
      seen_in       = seen_ff;
      prev_in       = prev_ff;
      dt_in         = dt_ff;
      valid_in      = valid_ff;
      pos_in        = pos_ff;
      att_in        = att_ff;
      roll_rate_in  = roll_rate_ff;
      pitch_rate_in = pitch_rate_ff;
      yaw_rate_in   = yaw_rate_ff;
      vel_in        = vel_ff;
      vdt_in        = vdt_ff;
      x_in          = x_ff;
      x2_in         = x2_ff;
      neg_in        = neg_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_ang_in    = rsp_ang_ff;
      rsp_pv_in     = rsp_pv_ff;

      unique case (ctrl.state)
         drpi_pkg::ST_IDLE: begin
            if (req_accept) begin
               // restart zeroes the pose before anything else
               if (req_chan.restart_origin) begin
                  for (int k = 0; k < 3; k++) begin
                     pos_in[k] = '0;
                     att_in[k] = '0;
                  end
               end
               prev_in       = req_chan.sample_time;
               seen_in       = 1'b1;
               valid_in      = seen_ff;
               dt_in         = dt_sat;
               roll_rate_in  = req_chan.roll_rate;
               pitch_rate_in = req_chan.pitch_rate;
               yaw_rate_in   = req_chan.yaw_rate;
               vel_in        = req_chan.linear_velocity;
            end
         end
         drpi_pkg::ST_ANGLE: begin
            case (ctrl.phase)
               drpi_pkg::OP_PITCH: att_in[0] = att_ff[0] + ang_step;
               drpi_pkg::OP_YAW:   att_in[1] = att_ff[1] + ang_step;
               drpi_pkg::OP_VDT:   att_in[2] = att_ff[2] - ang_step;
               default: ;
            endcase
         end
         drpi_pkg::ST_TRIG: begin
            case (ctrl.phase)
               drpi_pkg::TR_SQUARE: begin
                  x_in   = x_cur;
                  neg_in = trig_angle[15];
                  case (ctrl.axis)
                     drpi_pkg::AXIS_X: vdt_in = mul_prod[31:0];
                     drpi_pkg::AXIS_Y: pos_in[0] = pos_ff[0] - pos_step;
                     drpi_pkg::AXIS_Z: pos_in[1] = pos_ff[1] + pos_step;
                     default: ;
                  endcase
               end
               drpi_pkg::TR_CUBIC: begin
                  x2_in = t17[14:0];
               end
               default: ;
            endcase
         end
         drpi_pkg::ST_WRAP: begin
            pos_in[2] = pos_ff[2] + pos_step;
         end
         drpi_pkg::ST_FINISH: begin
            if (rsp_free) begin
               for (int k = 0; k < 3; k++) begin
                  rsp_pos_in[k] = 32'(pos_ff[k]);
                  rsp_ang_in[k] = ang16[k];
               end
               rsp_pv_in = valid_ff;
            end
         end
         default: ;
      endcase
   end

   // result register: load on finish, hold while the sink stalls
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         prev_ff      <= '0;
         valid_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            pos_ff[k] <= '0;
            att_ff[k] <= '0;
         end
      end else begin
         seen_ff      <= seen_in;
         prev_ff      <= prev_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         att_ff       <= att_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff         <= dt_in;
      roll_rate_ff  <= roll_rate_in;
      pitch_rate_ff <= pitch_rate_in;
      yaw_rate_ff   <= yaw_rate_in;
      vel_ff        <= vel_in;
      vdt_ff        <= vdt_in;
      x_ff          <= x_in;
      x2_ff         <= x2_in;
      neg_ff        <= neg_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_ang_ff    <= rsp_ang_in;
      rsp_pv_ff     <= rsp_pv_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pos_x       = rsp_pos_ff[0];
   assign rsp_chan.pos_y       = rsp_pos_ff[1];
   assign rsp_chan.pos_z       = rsp_pos_ff[2];
   assign rsp_chan.roll_angle  = rsp_ang_ff[0];
   assign rsp_chan.pitch_angle = rsp_ang_ff[1];
   assign rsp_chan.yaw_angle   = rsp_ang_ff[2];
   assign rsp_chan.pose_valid  = rsp_pv_ff;

   // first sample only records its time and goes straight to the result
   a_first_skips : assert property (@(posedge clock) disable iff (reset)
      (req_accept && !seen_ff) |=> (ctrl.state == drpi_pkg::ST_FINISH))
      else $error("first sample did not go straight to finish");

   // a later sample starts the angle steps with roll
   a_seen_computes : assert property (@(posedge clock) disable iff (reset)
      (req_accept && seen_ff) |=>
         (ctrl.state == drpi_pkg::ST_ANGLE && ctrl.phase == drpi_pkg::OP_ROLL))
      else $error("sample with a prior timestamp did not start the angle steps");

   // a finished pose lands in the result register and frees the input side
   a_finish_loads : assert property (@(posedge clock) disable iff (reset)
      (ctrl.state == drpi_pkg::ST_FINISH && rsp_free) |=>
         (rsp_chan.valid && req_chan.ready))
      else $error("finished pose not loaded into the result register");

   // no result can exist before a timestamp has been seen
   a_rsp_after_seen : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> seen_ff)
      else $error("result presented before any sample was taken");

endmodule

FILE: rtl/drpi_mul.sv
// Shared signed multiplier with a registered product.
// Depends on drpi_pkg for operand and product widths.
module drpi_mul (
   input  logic                                 clock,
   input  logic signed [drpi_pkg::MUL_A_W-1:0]  a,
   input  logic signed [drpi_pkg::MUL_B_W-1:0]  b,
   output logic signed [drpi_pkg::MUL_P_W-1:0]  prod
);

   logic signed [drpi_pkg::MUL_P_W-1:0] prod_ff;
   logic signed [drpi_pkg::MUL_P_W-1:0] prod_in;

   assign prod_in = a * b;
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

FILE: rtl/drpi_seq.sv
// Sequencer for the pose integrator: steps the shared multiplier through one sample.
// Depends on drpi_pkg for the state enum, operation codes and control struct.
module drpi_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               first_only,
   input  logic               rsp_free,
   output drpi_pkg::ctrl_type ctrl
);

   drpi_pkg::state_type state_ff, state_in;
   logic [2:0]          phase_ff, phase_in;
   logic [1:0]          axis_ff, axis_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= drpi_pkg::ST_IDLE;
         phase_ff <= drpi_pkg::OP_ROLL;
         axis_ff  <= drpi_pkg::AXIS_X;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         axis_ff  <= axis_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      axis_in  = axis_ff;
      unique case (state_ff)
         drpi_pkg::ST_IDLE: begin
            if (start) begin
               phase_in = drpi_pkg::OP_ROLL;
               axis_in  = drpi_pkg::AXIS_X;
               state_in = first_only ? drpi_pkg::ST_FINISH : drpi_pkg::ST_ANGLE;
            end
         end
         drpi_pkg::ST_ANGLE: begin
            if (phase_ff == drpi_pkg::OP_VDT) begin
               phase_in = drpi_pkg::TR_SQUARE;
               axis_in  = drpi_pkg::AXIS_X;
               state_in = drpi_pkg::ST_TRIG;
            end else begin
               phase_in = phase_ff + 3'd1;
            end
         end
         drpi_pkg::ST_TRIG: begin
            if (phase_ff == drpi_pkg::TR_POS) begin
               phase_in = drpi_pkg::TR_SQUARE;
               if (axis_ff == drpi_pkg::AXIS_Z) begin
                  state_in = drpi_pkg::ST_WRAP;
               end else begin
                  axis_in = axis_ff + 2'd1;
               end
            end else begin
               phase_in = phase_ff + 3'd1;
            end
         end
         drpi_pkg::ST_WRAP: begin
            state_in = drpi_pkg::ST_FINISH;
         end
         drpi_pkg::ST_FINISH: begin
            if (rsp_free) begin
               state_in = drpi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = drpi_pkg::ST_IDLE;
         end
      endcase
   end

   assign ctrl.state = state_ff;
   assign ctrl.phase = phase_ff;
   assign ctrl.axis  = axis_ff;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for dead_reckoning_pose_integrator: directed and random velocity samples,
// an in-bench pose predictor and an in-order result checker. Depends on drpi_pkg, drpi_if.
module tb_top;

   // Keep the sine coefficients signed so the polynomial stays in signed 64-bit math.
   localparam longint COEF_A = drpi_pkg::SIN_A;
   localparam longint COEF_B = drpi_pkg::SIN_B;
   localparam longint COEF_C = drpi_pkg::SIN_C;
   localparam longint STEP_SAT = drpi_pkg::DT_MAX;

   typedef struct {
      bit               restart_origin;
      bit [31:0]        sample_time;
      bit signed [15:0] linear_velocity;
      bit signed [23:0] roll_rate;
      bit signed [23:0] pitch_rate;
      bit signed [23:0] yaw_rate;
      bit               drain_first;   // hold this item until every pose is back
   } velocity_sample_type;

   typedef struct {
      bit [31:0] pos_x;
      bit [31:0] pos_y;
      bit [31:0] pos_z;
      bit [15:0] roll_angle;
      bit [15:0] pitch_angle;
      bit [15:0] yaw_angle;
      bit        pose_valid;
   } pose_type;

   logic clock;
   logic reset;

   drpi_req_if req_chan ();
   drpi_rsp_if rsp_chan ();

   dead_reckoning_pose_integrator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   velocity_sample_type pending_samples[$];
   pose_type            expected_poses[$];
   int                  mismatch_count;

   // Predictor state: last timestamp, whether one has been seen, and the pose.
   bit [31:0] last_stamp;
   bit        stamp_known;
   bit [31:0] track_x, track_y, track_z;
   bit [15:0] att_roll, att_pitch, att_yaw;

   // Angle increment: rate * dt in 2^-32 turn, rounded half up to 2^-16 turn.
   function automatic bit [15:0] angle_step(longint rate, longint dt);
      longint prod;
      prod = (rate * dt + 64'sd32768) >>> 16;
      return prod[15:0];
   endfunction

   // Distance increment: v * sine * dt in 2^-40 m, rounded half up to 2^-16 m.
   function automatic bit [31:0] travel_step(longint v, longint s, longint dt);
      longint prod;
      prod = (v * s * dt + (longint'(1) <<< (drpi_pkg::POS_SHIFT - 1))) >>>
             drpi_pkg::POS_SHIFT;
      return prod[31:0];
   endfunction

   // Q16 sine of a 16-bit binary angle: fold into a Q14 quarter wave, odd polynomial.
   function automatic longint sine_q16(bit [15:0] ang);
      longint frac, x, x2, t;
      frac = ang[13:0];
      x    = ang[14] ? (64'sd16384 - frac) : frac;
      x2   = (x * x) >>> 14;
      t    = (COEF_C * x2) >>> 14;
      t    = ((COEF_B - t) * x2) >>> 14;
      t    = ((COEF_A - t) * x) >>> 14;
      return ang[15] ? -t : t;
   endfunction

   // Advance the predicted pose by one sample and return the pose the block should emit.
   function automatic pose_type integrate_sample(velocity_sample_type s);
      pose_type  p;
      bit [31:0] diff;
      bit [15:0] yaw_quarter;
      longint    dt, v, sin_yaw, cos_yaw, sin_pitch;
      p.pose_valid = 1'b0;
      if (s.restart_origin) begin
         track_x   = '0;
         track_y   = '0;
         track_z   = '0;
         att_roll  = '0;
         att_pitch = '0;
         att_yaw   = '0;
      end
      if (!stamp_known) begin
         // first sample only records its time
         stamp_known = 1'b1;
         last_stamp  = s.sample_time;
      end else begin
         diff       = s.sample_time - last_stamp;
         dt         = (diff > 32'(STEP_SAT)) ? STEP_SAT : longint'(diff);
         last_stamp = s.sample_time;
         p.pose_valid = 1'b1;
         // angles first; yaw rate is subtracted
         att_roll  = att_roll + angle_step(longint'(s.roll_rate), dt);
         att_pitch = att_pitch + angle_step(longint'(s.pitch_rate), dt);
         att_yaw   = att_yaw - angle_step(longint'(s.yaw_rate), dt);
         // then the position, from the updated angles
         yaw_quarter = att_yaw + drpi_pkg::QUARTER16;
         v         = longint'(s.linear_velocity);
         sin_yaw   = sine_q16(att_yaw);
         cos_yaw   = sine_q16(yaw_quarter);
         sin_pitch = sine_q16(att_pitch);
         track_x = track_x - travel_step(v, sin_yaw, dt);
         track_y = track_y + travel_step(v, cos_yaw, dt);
         track_z = track_z + travel_step(v, sin_pitch, dt);
      end
      p.pos_x       = track_x;
      p.pos_y       = track_y;
      p.pos_z       = track_z;
      p.roll_angle  = att_roll;
      p.pitch_angle = att_pitch;
      p.yaw_angle   = att_yaw;
      return p;
   endfunction

   // Draw the wait before the next item; now and then flip into or out of a no-gap stretch.
   function automatic int draw_wait(inout bit no_gaps);
      if ($urandom_range(0, 39) == 0)
         no_gaps = !no_gaps;
      return no_gaps ? 0 : int'($urandom_range(0, 14));
   endfunction

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s expected 0x%0h actual 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic queue_sample(bit restart, bit [31:0] stamp, int v, int rr, int pr, int yr,
                               bit drain);
      velocity_sample_type s;
      s.restart_origin  = restart;
      s.sample_time     = stamp;
      s.linear_velocity = 16'(v);
      s.roll_rate       = 24'(rr);
      s.pitch_rate      = 24'(pr);
      s.yaw_rate        = 24'(yr);
      s.drain_first     = drain;
      pending_samples.insert(pending_samples.size(), s);
   endtask

   // Clock: 20 ns period.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Drive every block input to a known value before the first edge.
   initial begin
      req_chan.valid           = 1'b0;
      req_chan.restart_origin  = 1'b0;
      req_chan.sample_time     = '0;
      req_chan.linear_velocity = '0;
      req_chan.roll_rate       = '0;
      req_chan.pitch_rate      = '0;
      req_chan.yaw_rate        = '0;
      rsp_chan.ready           = 1'b0;
   end

   // Sample driver: present the oldest pending item after its drawn gap, hold it until taken.
   velocity_sample_type on_bus;
   int                  send_gap;
   bit                  send_burst;

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) begin
            // item taken at this edge: predict its pose, draw the gap to the next one
            expected_poses.insert(expected_poses.size(), integrate_sample(on_bus));
            send_gap = draw_wait(send_burst);
         end
         if (send_gap > 0) begin
            send_gap--;
            req_chan.valid <= 1'b0;
         end else if (pending_samples.size() != 0 &&
                      (!pending_samples[0].drain_first || expected_poses.size() == 0)) begin
            on_bus = pending_samples.pop_front();
            req_chan.valid           <= 1'b1;
            req_chan.restart_origin  <= on_bus.restart_origin;
            req_chan.sample_time     <= on_bus.sample_time;
            req_chan.linear_velocity <= on_bus.linear_velocity;
            req_chan.roll_rate       <= on_bus.roll_rate;
            req_chan.pitch_rate      <= on_bus.pitch_rate;
            req_chan.yaw_rate        <= on_bus.yaw_rate;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Pose monitor: check each taken result against the oldest prediction, stall at random.
   int hold_left;
   bit stall_burst;

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_poses.size() == 0) begin
               $error("pose result with no sample outstanding");
               mismatch_count++;
            end else begin
               pose_type want;
               want = expected_poses.pop_front();
               compare_field("pos_x", want.pos_x, rsp_chan.pos_x);
               compare_field("pos_y", want.pos_y, rsp_chan.pos_y);
               compare_field("pos_z", want.pos_z, rsp_chan.pos_z);
               compare_field("roll_angle", 32'(want.roll_angle), 32'(rsp_chan.roll_angle));
               compare_field("pitch_angle", 32'(want.pitch_angle), 32'(rsp_chan.pitch_angle));
               compare_field("yaw_angle", 32'(want.yaw_angle), 32'(rsp_chan.yaw_angle));
               compare_field("pose_valid", 32'(want.pose_valid), 32'(rsp_chan.pose_valid));
            end
            hold_left = draw_wait(stall_burst);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      bit [31:0] stamp;
      int        pick, k;
      bit [31:0] step;
      int        rr, pr, yr;

      mismatch_count = 0;
      stamp_known    = 1'b0;
      last_stamp     = '0;
      track_x        = '0;
      track_y        = '0;
      track_z        = '0;
      att_roll       = '0;
      att_pitch      = '0;
      att_yaw        = '0;
      send_burst     = 1'b0;
      stall_burst    = 1'b0;

      reset = 1'b1;

      // Directed part.
      stamp = 32'h0000_1000;
      // first sample: only records its timestamp, pose_valid low
      queue_sample(1'b0, stamp, 32767, 8388607, -8388608, 1234, 1'b0);
      // equal timestamp: zero step, pose held
      queue_sample(1'b0, stamp, -32768, 8388607, 8388607, 8388607, 1'b0);
      stamp += 100;
      queue_sample(1'b0, stamp, 32767, 8388607, 8388607, 8388607, 1'b0);
      // exactly the largest step, most negative everything
      stamp += 65535;
      queue_sample(1'b0, stamp, -32768, -8388608, -8388608, -8388608, 1'b0);
      // long step: saturates
      stamp += 70000;
      queue_sample(1'b0, stamp, 12345, -4000000, 3000000, -777777, 1'b0);
      // backward step: saturates too
      stamp -= 5;
      queue_sample(1'b0, stamp, 256, 1000, -1000, 500, 1'b0);
      // restart from the origin, after the pipe has drained
      stamp += 50;
      queue_sample(1'b1, stamp, 256, 65536, 65536, 65536, 1'b1);
      // walk yaw and pitch in eighth turns through every quadrant
      stamp += 16;
      queue_sample(1'b1, stamp, 0, 0, 0, 0, 1'b0);
      for (k = 0; k < 7; k++) begin
         stamp += 16384;
         queue_sample(1'b0, stamp, 32767, 0, 32768, -32768, 1'b0);
      end
      // timestamp wrap-around
      queue_sample(1'b0, 32'hFFFF_FFF0, -300, 2000, -2000, 3000, 1'b0);
      queue_sample(1'b0, 32'h0000_0010, -32768, 2000, -2000, 3000, 1'b0);
      queue_sample(1'b0, 32'hFFFF_FFFF, 32767, -8388608, 8388607, -1, 1'b0);
      // restart with an all-zero sample, one unit later after wrap
      queue_sample(1'b1, 32'h0000_0000, 0, 0, 0, 0, 1'b0);
      stamp = 32'h0000_0000;

      // Random part: mostly short forward steps, with zero, long and backward steps mixed in.
      for (k = 0; k < 500; k++) begin
         pick = $urandom_range(0, 19);
         if (pick == 0)
            step = 0;
         else if (pick == 1)
            step = $urandom();
         else if (pick == 2)
            step = $urandom_range(65534, 65537);
         else
            step = $urandom_range(1, 4000);
         stamp += step;
         if ($urandom_range(0, 1) == 0) begin
            rr = int'($urandom());
            pr = int'($urandom());
            yr = int'($urandom());
         end else begin
            rr = int'($urandom_range(0, 4000)) - 2000;
            pr = int'($urandom_range(0, 4000)) - 2000;
            yr = int'($urandom_range(0, 4000)) - 2000;
         end
         queue_sample($urandom_range(0, 31) == 0, stamp, int'($urandom()), rr, pr, yr,
                      k == 250);
      end

      // Hold reset at the start, then release it for good.
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Drain: every item sent and every pose back, then let the block settle.
      while (pending_samples.size() != 0 || req_chan.valid || expected_poses.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

FILE: dead_reckoning_pose_integrator.f
rtl/drpi_pkg.sv
rtl/drpi_if.sv
rtl/drpi_mul.sv
rtl/drpi_seq.sv
rtl/dead_reckoning_pose_integrator.sv
tb/sv/tb_top.sv
